FILE: design/gitp_pkg.sv
`timescale 1ns / 1ps

package gitp_pkg;

   localparam int TEXT_LENGTH_BITS = 16;
   localparam int VALUE_BITS       = 32;
   localparam int MAG_BITS         = VALUE_BITS - 1;
   localparam int POS_OUT_BITS     = TEXT_LENGTH_BITS + 1;

   // tdata of the result: value, next_position, position_valid, padded to bytes
   localparam int RSP_FIELD_BITS = VALUE_BITS + POS_OUT_BITS + 1;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [MAG_BITS-1:0] MAX_MAG = {MAG_BITS{1'b1}};
   localparam logic [MAG_BITS-1:0] MAG_LIMIT = MAX_MAG / 10;
   localparam logic [3:0] MAG_LIMIT_DIGIT = 4'(MAX_MAG % 10);

   localparam logic [TEXT_LENGTH_BITS-1:0] POS_MAX = {TEXT_LENGTH_BITS{1'b1}};

   localparam logic [7:0] DECIMAL_MARK_RESET = 8'd46;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOITEM   = 2'd1,
      ST_ILLEGAL  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_POSTSIGN,
      PH_MARK_FIRST,
      PH_DIGITS,
      PH_MARK_MID,
      PH_DONE
   } phase_type;

   // one classified character as it travels from front to back
   typedef struct packed {
      logic                        blank;
      logic                        digit;
      logic                        mark;
      logic                        plus;
      logic                        minus;
      logic [3:0]                  digit_val;
      logic [TEXT_LENGTH_BITS-1:0] pos;
      logic                        last;
   } item_type;

endpackage

FILE: design/grouped_integer_text_parser.sv
`timescale 1ns / 1ps

// Parses one signed decimal number per text field, one character per beat,
// tlast on the last character. Leading blanks, an optional sign, blanks,
// then digit groups joined by blanks or by the decimal mark (csr register,
// reset '.'); all digits form one integer. One result beat comes on the
// last character: value, one-based position after the last digit, a
// position-valid flag and a status in tuser (0 ok, 1 no item, 2 illegal,
// 3 overflow). The front classifies each character and counts positions,
// a two-entry queue follows, and the back runs the parse state and the
// multiply-by-ten accumulator; one character is taken every cycle when the
// queue and result do not stall, and rsp_tvalid is driven from a result
// register. Write the decimal mark only while no field is in flight.
module grouped_integer_text_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [7:0]                         csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // character
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // value [31:0], next_position [48:32], position_valid [49], zero fill
   output logic [gitp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [1:0]                         rsp_tuser    // status
);
   import gitp_pkg::*;

   item_type front_item;
   item_type back_item;
   logic     front_valid;
   logic     front_ready;
   logic     back_valid;
   logic     back_ready;

   gitp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .item_valid  (front_valid),
      .item_ready  (front_ready),
      .item        (front_item)
   );

   gitp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   gitp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: design/gitp_front.sv
`timescale 1ns / 1ps

module gitp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   output logic               item_valid,
   input  logic               item_ready,
   output gitp_pkg::item_type item
);
   import gitp_pkg::*;

   logic [7:0]                  mark_ff;
   logic [TEXT_LENGTH_BITS-1:0] count_ff;
   logic [TEXT_LENGTH_BITS-1:0] count_in;
   logic [TEXT_LENGTH_BITS-1:0] pos;
   logic                        fire;

   assign req_tready = item_ready;
   assign item_valid = req_tvalid;
   assign fire       = req_tvalid && item_ready;

   // saturate the position at the top of the counter
   assign pos = (count_ff == POS_MAX) ? POS_MAX : count_ff + 1'b1;
   assign count_in = req_tlast ? '0 : pos;

   always_comb begin
      item.blank     = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_TAB);
      item.digit     = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      item.mark      = (req_tdata == mark_ff);
      item.plus      = (req_tdata == CHAR_PLUS);
      item.minus     = (req_tdata == CHAR_MINUS);
      item.digit_val = 4'(req_tdata - CHAR_ZERO);
      item.pos       = pos;
      item.last      = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= DECIMAL_MARK_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mark_ff <= csr_wr_data;
         end
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

endmodule

FILE: design/gitp_queue.sv
`timescale 1ns / 1ps

module gitp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  gitp_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output gitp_pkg::item_type pop_item
);
   import gitp_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       push;
   logic       pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

FILE: design/gitp_back.sv
`timescale 1ns / 1ps

module gitp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  gitp_pkg::item_type                  item,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gitp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic [1:0]                          rsp_tuser
);
   import gitp_pkg::*;

   phase_type                   phase_ff;
   phase_type                   phase_in;
   logic                        negative_ff;
   logic                        negative_in;
   logic [MAG_BITS-1:0]         acc_ff;
   logic [MAG_BITS-1:0]         acc_in;
   logic [TEXT_LENGTH_BITS-1:0] ldp_ff;
   logic [TEXT_LENGTH_BITS-1:0] ldp_in;
   status_type                  outcome_ff;
   status_type                  outcome_in;

   logic                        rsp_valid_ff;
   logic [VALUE_BITS-1:0]       value_ff;
   logic [VALUE_BITS-1:0]       value_in;
   logic [POS_OUT_BITS-1:0]     npos_ff;
   logic [POS_OUT_BITS-1:0]     npos_in;
   logic                        pvalid_ff;
   status_type                  status_ff;
   status_type                  status_in;

   logic                        fire;
   logic                        take_digit;
   logic                        overflow;
   logic                        set_sign;
   logic                        finish;
   status_type                  finish_code;
   logic [MAG_BITS+3:0]         acc_wide;
   logic [VALUE_BITS-1:0]       mag_ext;

   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid && item_ready;

   assign overflow = (acc_ff > MAG_LIMIT) ||
                     ((acc_ff == MAG_LIMIT) && (item.digit_val > MAG_LIMIT_DIGIT));
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) +
                     (MAG_BITS + 4)'(item.digit_val);

   // decode: what this character does in the current phase
   always_comb begin
      take_digit  = 1'b0;
      set_sign    = 1'b0;
      finish      = 1'b0;
      finish_code = ST_OK;
      unique case (phase_ff)
         PH_LEAD, PH_POSTSIGN: begin
            if (item.blank) begin
               finish = 1'b0;
            end else if ((phase_ff == PH_LEAD) && (item.plus || item.minus)) begin
               set_sign = 1'b1;
            end else if (item.digit) begin
               take_digit = 1'b1;
            end else if (!item.mark) begin
               finish      = 1'b1;
               finish_code = ST_NOITEM;
            end
         end
         PH_MARK_FIRST: begin
            if (item.digit) begin
               take_digit = 1'b1;
            end else begin
               finish      = 1'b1;
               finish_code = ST_ILLEGAL;
            end
         end
         PH_DIGITS: begin
            if (item.digit) begin
               take_digit = 1'b1;
            end else if (!item.blank && !item.mark) begin
               finish      = 1'b1;
               finish_code = ST_OK;
            end
         end
         PH_MARK_MID: begin
            if (item.digit) begin
               take_digit = 1'b1;
            end else begin
               finish      = 1'b1;
               finish_code = ST_OK;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase
      if (take_digit && overflow) begin
         finish      = 1'b1;
         finish_code = ST_OVERFLOW;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_LEAD, PH_POSTSIGN: begin
            if (finish) begin
               phase_in = PH_DONE;
            end else if (set_sign) begin
               phase_in = PH_POSTSIGN;
            end else if (take_digit) begin
               phase_in = PH_DIGITS;
            end else if (!item.blank && item.mark) begin
               phase_in = PH_MARK_FIRST;
            end
         end
         PH_MARK_FIRST, PH_MARK_MID: begin
            phase_in = finish ? PH_DONE : PH_DIGITS;
         end
         PH_DIGITS: begin
            if (finish) begin
               phase_in = PH_DONE;
            end else if (!take_digit && !item.blank && item.mark) begin
               phase_in = PH_MARK_MID;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      negative_in = set_sign ? item.minus : negative_ff;
      acc_in      = acc_ff;
      ldp_in      = ldp_ff;
      outcome_in  = finish ? finish_code : outcome_ff;
      if (take_digit && !overflow) begin
         acc_in = acc_wide[MAG_BITS-1:0];
         ldp_in = item.pos;
      end

      unique case (phase_in)
         PH_LEAD, PH_POSTSIGN: status_in = ST_NOITEM;
         PH_MARK_FIRST:        status_in = ST_ILLEGAL;
         PH_DIGITS, PH_MARK_MID: status_in = ST_OK;
         default:              status_in = outcome_in;
      endcase

      mag_ext  = {1'b0, acc_in};
      value_in = '0;
      if ((status_in == ST_OK) || (status_in == ST_OVERFLOW)) begin
         value_in = negative_in ? (VALUE_BITS'(0) - mag_ext) : mag_ext;
      end
      npos_in = '0;
      if (status_in == ST_OK) begin
         npos_in = {1'b0, ldp_in} + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && item.last) begin
         value_ff  <= value_in;
         npos_ff   <= npos_in;
         pvalid_ff <= (status_in == ST_OK);
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         ldp_ff       <= '0;
         outcome_ff   <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            if (item.last) begin
               phase_ff    <= PH_LEAD;
               negative_ff <= 1'b0;
               acc_ff      <= '0;
               ldp_ff      <= '0;
               outcome_ff  <= ST_OK;
            end else begin
               phase_ff    <= phase_in;
               negative_ff <= negative_in;
               acc_ff      <= acc_in;
               ldp_ff      <= ldp_in;
               outcome_ff  <= outcome_in;
            end
         end
         if (fire && item.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                        pvalid_ff, npos_ff, value_ff};
   assign rsp_tuser  = status_ff;

endmodule
